// ===== rtl/pda_pkg.sv =====
package pda_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned BANK_W      = ADDR_W - 1;
  localparam int unsigned BANK_DEPTH  = STACK_DEPTH / 2;
  localparam int unsigned LEVEL_W     = 7;

  // Stack symbol codes
  typedef logic [3:0] sym_t;
  localparam sym_t SYM_PCT = 4'd0;
  localparam sym_t SYM_DOL = 4'd1;
  localparam sym_t SYM_X   = 4'd2;
  localparam sym_t SYM_Y   = 4'd3;
  localparam sym_t SYM_Z   = 4'd4;
  localparam sym_t SYM_A   = 4'd5;
  localparam sym_t SYM_U   = 4'd6;
  localparam sym_t SYM_G   = 4'd7;
  localparam sym_t SYM_C   = 4'd8;
  localparam sym_t SYM_RP  = 4'd9;

  // Input characters
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_G   = 8'h67;
  localparam logic [7:0] CH_C   = 8'h63;
  localparam logic [7:0] CH_END = 8'h24;
  localparam logic [7:0] CH_LP  = 8'h28;
  localparam logic [7:0] CH_RP  = 8'h29;

  // Run status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Request codes
  localparam logic REQ_FEED    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Language codes
  localparam logic LANG_HAIRPIN = 1'b0;
  localparam logic LANG_BRACKET = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [LEVEL_W-1:0] stack_level;
  } out_t;

  // Decoded rule: pop top, push len symbols (push[0] deepest)
  typedef struct packed {
    logic            hit;
    logic            win;
    logic [1:0]      len;
    sym_t [2:0]      push;
  } rule_t;

  function automatic rule_t rule_lookup(input logic lang, input logic [7:0] ch,
                                        input sym_t top);
    rule_t r;
    logic  is_base;
    sym_t  comp;
    r       = '0;
    is_base = 1'b1;
    comp    = SYM_PCT;
    unique case (ch)
      CH_A:    comp = SYM_U;
      CH_U:    comp = SYM_A;
      CH_G:    comp = SYM_C;
      CH_C:    comp = SYM_G;
      default: is_base = 1'b0;
    endcase
    if (lang == LANG_BRACKET) begin
      unique case (top)
        SYM_DOL: begin
          if (ch == CH_LP) begin
            r.hit = 1'b1; r.len = 2'd1; r.push[0] = SYM_RP;
          end
        end
        SYM_PCT: begin
          if (ch == CH_LP) begin
            r.hit = 1'b1; r.len = 2'd2; r.push[0] = SYM_PCT; r.push[1] = SYM_RP;
          end else if (ch == CH_END) begin
            r.hit = 1'b1; r.win = 1'b1;
          end
        end
        SYM_RP: begin
          if (ch == CH_LP) begin
            r.hit = 1'b1; r.len = 2'd2; r.push[0] = SYM_RP; r.push[1] = SYM_RP;
          end else if (ch == CH_RP) begin
            r.hit = 1'b1;
          end
        end
        default: r.hit = 1'b0;
      endcase
    end else begin
      unique case (top)
        SYM_DOL: begin
          r.hit = is_base; r.len = 2'd2; r.push[0] = comp; r.push[1] = SYM_X;
        end
        SYM_X: begin
          r.hit = is_base; r.len = 2'd2; r.push[0] = comp; r.push[1] = SYM_Y;
        end
        SYM_Y: begin
          r.hit = is_base; r.len = 2'd3;
          r.push[0] = comp; r.push[1] = SYM_Z; r.push[2] = SYM_G;
        end
        SYM_Z: begin
          r.hit = (ch == CH_A) || (ch == CH_C);
          r.len = 2'd2; r.push[0] = SYM_A; r.push[1] = SYM_A;
        end
        SYM_A:   r.hit = (ch == CH_A);
        SYM_U:   r.hit = (ch == CH_U);
        SYM_G:   r.hit = (ch == CH_G);
        SYM_C:   r.hit = (ch == CH_C);
        SYM_PCT: begin
          r.hit = (ch == CH_END); r.win = 1'b1;
        end
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/pushdown_recognizer.sv =====
// Pushdown recognizer, one character per word on the input channel.
// Input word: req_type (0 feed symbol, 1 restart) and an ASCII symbol.
// Output word: status (0 in progress, 1 success, 2 fail) and the stack
// level after the step. Every input word yields exactly one output word.
// Config channel: one write-only bit, language_select (0 RNA hairpin rules,
// 1 parenthesis rules); write it only while the block is idle.
// Output: each result is registered into the output buffer on acceptance.
// Throughput: one word per cycle while in_ready_o is high. The top two stack
// entries live in flops and the stack body in two 32-entry banks (even/odd
// entries), so a push of three spills two entries in the same cycle and a
// pop reads the entry three below the top, which is ready by the next step.
// Reset: stack holds '%' then '$', level 2, status in progress, language 0.
// No clearing pass; bank entries are only read after a spill wrote them.
// Stall: a two-word output buffer lets one more word in while a result
// waits; in_ready_o drops only when both slots hold undelivered results.
module pushdown_recognizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pda_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pda_pkg::out_t out_data_o
);
  import pda_pkg::*;

  // Architectural state
  logic             lang_q;
  logic [1:0]       status_q, status_d;
  logic [PTR_W-1:0] sp_q, sp_d;
  sym_t             top_q, top_d;      // entry sp-1
  sym_t             below_q, below_d;  // entry sp-2
  sym_t             deep_q, deep_d;    // entry sp-3 when not taken from the banks
  logic             deep_ram_q, deep_ram_d;

  // Stack body banks
  sym_t             even_mem [BANK_DEPTH];
  sym_t             odd_mem  [BANK_DEPTH];
  sym_t             even_rd_q, odd_rd_q;
  logic             rd_par_q;

  // Output buffer
  out_t             out_q, skid_q, res;
  logic             out_valid_q, skid_valid_q;

  logic             accept, step, restart, pop_out;
  rule_t            rule;
  logic [PTR_W:0]   sp_after;
  logic             can_run, ok;
  sym_t             deep_eff;
  logic [ADDR_W-1:0] wa_addr, wb_addr, rd_addr;
  logic             wa_en, wb_en, rd_en;
  logic             even_we, odd_we;
  logic [BANK_W-1:0] even_idx, odd_idx;
  sym_t             even_wdata, odd_wdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign step        = accept && (in_data_i.req_type == REQ_FEED);
  assign restart     = accept && (in_data_i.req_type == REQ_RESTART);
  assign pop_out     = out_valid_q && out_ready_i;

  assign deep_eff = deep_ram_q ? (rd_par_q ? odd_rd_q : even_rd_q) : deep_q;

  assign rule     = rule_lookup(lang_q, in_data_i.symbol, top_q);
  assign sp_after = {1'b0, sp_q} - (PTR_W+1)'(1) + (PTR_W+1)'(rule.len);
  assign can_run  = (status_q == ST_RUN) && (sp_q != '0);
  assign ok       = can_run && rule.hit && (sp_after <= (PTR_W+1)'(STACK_DEPTH));

  // Spill addresses: old second entry, and the deepest pushed symbol
  assign wa_addr = ADDR_W'(sp_q - PTR_W'(2));
  assign wb_addr = ADDR_W'(sp_q - PTR_W'(1));
  assign rd_addr = ADDR_W'(sp_q - PTR_W'(4));
  assign wa_en   = step && ok && (rule.len >= 2'd2);
  assign wb_en   = step && ok && (rule.len == 2'd3);
  assign rd_en   = step && ok && (rule.len == 2'd0);

  always_comb begin
    even_we    = 1'b0;
    odd_we     = 1'b0;
    even_idx   = wa_addr[ADDR_W-1:1];
    odd_idx    = wa_addr[ADDR_W-1:1];
    even_wdata = below_q;
    odd_wdata  = below_q;
    if (wa_en) begin
      if (wa_addr[0]) odd_we = 1'b1;
      else even_we = 1'b1;
    end
    if (wb_en) begin
      if (wb_addr[0]) begin
        odd_we    = 1'b1;
        odd_idx   = wb_addr[ADDR_W-1:1];
        odd_wdata = rule.push[0];
      end else begin
        even_we    = 1'b1;
        even_idx   = wb_addr[ADDR_W-1:1];
        even_wdata = rule.push[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (even_we) even_mem[even_idx] <= even_wdata;
    if (odd_we) odd_mem[odd_idx] <= odd_wdata;
    if (rd_en) begin
      even_rd_q <= even_mem[rd_addr[ADDR_W-1:1]];
      odd_rd_q  <= odd_mem[rd_addr[ADDR_W-1:1]];
      rd_par_q  <= rd_addr[0];
    end
  end

  // Step: update status, pointer and the cached top entries
  always_comb begin
    status_d   = status_q;
    sp_d       = sp_q;
    top_d      = top_q;
    below_d    = below_q;
    deep_d     = deep_eff;
    deep_ram_d = 1'b0;
    if (restart) begin
      status_d = ST_RUN;
      sp_d     = PTR_W'(2);
      top_d    = SYM_DOL;
      below_d  = SYM_PCT;
    end else if (step) begin
      if (ok) begin
        status_d = rule.win ? ST_OK : ST_RUN;
        sp_d     = sp_after[PTR_W-1:0];
        unique case (rule.len)
          2'd0: begin
            top_d      = below_q;
            below_d    = deep_eff;
            deep_ram_d = 1'b1;
          end
          2'd1: top_d = rule.push[0];
          2'd2: begin
            top_d   = rule.push[1];
            below_d = rule.push[0];
            deep_d  = below_q;
          end
          2'd3: begin
            top_d   = rule.push[2];
            below_d = rule.push[1];
            deep_d  = rule.push[0];
          end
          default: top_d = top_q;
        endcase
      end else begin
        status_d   = ST_FAIL;
        deep_d     = deep_q;
        deep_ram_d = deep_ram_q;
      end
    end else begin
      deep_d     = deep_q;
      deep_ram_d = deep_ram_q;
    end
  end

  assign res.status      = status_d;
  assign res.stack_level = LEVEL_W'(sp_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lang_q     <= LANG_HAIRPIN;
      status_q   <= ST_RUN;
      sp_q       <= PTR_W'(2);
      top_q      <= SYM_DOL;
      below_q    <= SYM_PCT;
      deep_q     <= SYM_PCT;
      deep_ram_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) lang_q <= cfg_data_i;
      status_q   <= status_d;
      sp_q       <= sp_d;
      top_q      <= top_d;
      below_q    <= below_d;
      deep_q     <= deep_d;
      deep_ram_q <= deep_ram_d;
    end
  end

  // Two-word output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop_out && accept) begin
        out_valid_q <= 1'b1;
      end else if (pop_out) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        if (out_valid_q) skid_valid_q <= 1'b1;
        else out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_out && accept) begin
      out_q <= res;
    end else if (pop_out) begin
      out_q <= skid_q;
    end else if (accept) begin
      if (out_valid_q) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
